// ----- src/hgrc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// hgrc_pkg
// Constants, codes and suffix decode shared by the GET request classifier.
// ============================================================================
package hgrc_pkg;

    localparam int MAX_REQUEST_BYTES = 4096;
    localparam int MAX_PATH_LEN      = 255;

    localparam int BYTE_CNT_W = $clog2(MAX_REQUEST_BYTES);
    localparam int PATH_CNT_W = 9;

    localparam logic [BYTE_CNT_W-1:0] BYTE_LIMIT = BYTE_CNT_W'(MAX_REQUEST_BYTES - 2);
    localparam logic [PATH_CNT_W-1:0] PATH_MAX   = PATH_CNT_W'(MAX_PATH_LEN);
    localparam logic [PATH_CNT_W-1:0] INDEX_LEN  = PATH_CNT_W'(11);

    // status codes
    typedef logic [2:0] status_t;
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_BAD_METH  = 3'd1;
    localparam status_t ST_BAD_REQ   = 3'd2;
    localparam status_t ST_FORBIDDEN = 3'd3;
    localparam status_t ST_TOO_LARGE = 3'd4;

    // content type codes
    typedef logic [2:0] ctype_t;
    localparam ctype_t CT_OCTET = 3'd0;
    localparam ctype_t CT_HTML  = 3'd1;
    localparam ctype_t CT_JPEG  = 3'd2;
    localparam ctype_t CT_PNG   = 3'd3;
    localparam ctype_t CT_CSS   = 3'd4;
    localparam ctype_t CT_JS    = 3'd5;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [31:0] METHOD_WORD = "GET ";

    localparam logic [39:0] SFX_HTML = ".html";
    localparam logic [31:0] SFX_HTM  = ".htm";
    localparam logic [39:0] SFX_JPEG = ".jpeg";
    localparam logic [31:0] SFX_JPG  = ".jpg";
    localparam logic [31:0] SFX_PNG  = ".png";
    localparam logic [31:0] SFX_CSS  = ".css";
    localparam logic [23:0] SFX_JS   = ".js";

    // expected method byte at position idx
    function automatic logic [7:0] method_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = METHOD_WORD[31:24];
            2'd1:    c = METHOD_WORD[23:16];
            2'd2:    c = METHOD_WORD[15:8];
            default: c = METHOD_WORD[7:0];
        endcase
        return c;
    endfunction

    // content type from the last five path bytes, newest in the low byte
    function automatic ctype_t suffix_kind(input logic [39:0] win,
                                           input logic [PATH_CNT_W-1:0] len);
        ctype_t k;
        if (len < PATH_CNT_W'(4))
            k = CT_OCTET;
        else if (win == SFX_HTML || win[31:0] == SFX_HTM)
            k = CT_HTML;
        else if (win == SFX_JPEG || win[31:0] == SFX_JPG)
            k = CT_JPEG;
        else if (win[31:0] == SFX_PNG)
            k = CT_PNG;
        else if (win[31:0] == SFX_CSS)
            k = CT_CSS;
        else if (win[23:0] == SFX_JS)
            k = CT_JS;
        else
            k = CT_OCTET;
        return k;
    endfunction

endpackage

// ----- src/http_get_request_classifier_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// http_get_request_classifier_unit
// Byte-serial GET request line classifier: one verdict per request.
// ============================================================================
//  channel  handshake             payload
//  -------  --------------------  ------------------------------------------
//  in       in_valid / in_ready   data_byte, new_request
//  out      out_valid / out_ready status, path_length, content_type,
//                                 index_substituted
//
//  One byte per cycle while in_ready is high. The parse state updates in the
//  accept cycle; a verdict lands in the output register and is visible the
//  cycle after. in_ready stays high while the output register is empty or
//  being drained, so a waiting verdict stalls input only when out_ready is low.
//  rst_n (async) clears all parse state and the output valid flag.
// ============================================================================
module http_get_request_classifier_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    input  logic                          new_request,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic [hgrc_pkg::PATH_CNT_W-1:0] path_length,
    output logic [2:0]                    content_type,
    output logic                          index_substituted
);
    import hgrc_pkg::*;

    localparam logic [1:0] PH_METHOD = 2'd0;
    localparam logic [1:0] PH_PATH   = 2'd1;
    localparam logic [1:0] PH_CLOSED = 2'd2;

    logic [BYTE_CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [2:0]            term_prog_reg, term_prog_next;
    logic [2:0]            meth_prog_reg, meth_prog_next;
    logic                  meth_bad_reg, meth_bad_next;
    logic [1:0]            phase_reg, phase_next;
    logic [PATH_CNT_W-1:0] path_cnt_reg, path_cnt_next;
    logic [7:0]            prev_byte_reg, prev_byte_next;
    logic                  dotdot_reg, dotdot_next;
    logic [39:0]           sfx_reg, sfx_next;
    logic [7:0]            first_byte_reg, first_byte_next;
    logic                  done_reg, done_next;

    logic                  out_valid_reg;
    status_t               status_reg, status_next;
    logic [PATH_CNT_W-1:0] plen_reg, plen_next;
    ctype_t                ctype_reg, ctype_next;
    logic                  idx_reg, idx_next;
    logic                  verdict;
    logic                  in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        // state as seen after an optional new_request clear
        if (new_request)
        begin
            byte_count_next = '0;
            term_prog_next  = '0;
            meth_prog_next  = '0;
            meth_bad_next   = 1'b0;
            phase_next      = PH_METHOD;
            path_cnt_next   = '0;
            prev_byte_next  = CH_DOT;
            dotdot_next     = 1'b0;
            sfx_next        = '0;
            first_byte_next = '0;
            done_next       = 1'b0;
        end
        else
        begin
            byte_count_next = byte_count_reg;
            term_prog_next  = term_prog_reg;
            meth_prog_next  = meth_prog_reg;
            meth_bad_next   = meth_bad_reg;
            phase_next      = phase_reg;
            path_cnt_next   = path_cnt_reg;
            prev_byte_next  = prev_byte_reg;
            dotdot_next     = dotdot_reg;
            sfx_next        = sfx_reg;
            first_byte_next = first_byte_reg;
            done_next       = done_reg;
        end

        verdict     = 1'b0;
        status_next = ST_OK;
        plen_next   = '0;
        ctype_next  = CT_OCTET;
        idx_next    = 1'b0;

        if (!done_next)
        begin
            byte_count_next = byte_count_next + 1'b1;

            case (phase_next)
                PH_METHOD:
                begin
                    if (data_byte != method_char(meth_prog_next[1:0]))
                        meth_bad_next = 1'b1;
                    meth_prog_next = meth_prog_next + 1'b1;
                    if (meth_prog_next >= 3'd4)
                    begin
                        phase_next = PH_PATH;
                        sfx_next   = {32'd0, CH_DOT};
                    end
                end
                PH_PATH:
                begin
                    if (data_byte == CH_SPACE)
                        phase_next = PH_CLOSED;
                    else
                    begin
                        if (path_cnt_next == '0)
                            first_byte_next = data_byte;
                        if (path_cnt_next <= PATH_MAX)
                            path_cnt_next = path_cnt_next + 1'b1;
                        if (prev_byte_next == CH_DOT && data_byte == CH_DOT)
                            dotdot_next = 1'b1;
                        prev_byte_next = data_byte;
                        sfx_next       = {sfx_next[31:0], data_byte};
                    end
                end
                default: ;
            endcase

            // CR LF CR LF tracker
            if (term_prog_next == 3'd0 || term_prog_next == 3'd2)
                term_prog_next = (data_byte == CH_CR) ? term_prog_next + 1'b1 : 3'd0;
            else if (data_byte == CH_LF)
                term_prog_next = term_prog_next + 1'b1;
            else
                term_prog_next = (data_byte == CH_CR) ? 3'd1 : 3'd0;

            if (term_prog_next >= 3'd4)
            begin
                verdict = 1'b1;
                if (meth_bad_next || meth_prog_next < 3'd4)
                    status_next = ST_BAD_METH;
                else if (phase_next != PH_CLOSED || path_cnt_next == '0 ||
                         path_cnt_next > PATH_MAX)
                begin
                    status_next = ST_BAD_REQ;
                    plen_next   = path_cnt_next;
                end
                else if (dotdot_next)
                begin
                    status_next = ST_FORBIDDEN;
                    plen_next   = path_cnt_next;
                end
                else if (path_cnt_next == PATH_CNT_W'(1) && first_byte_next == CH_SLASH)
                begin
                    // lone "/" serves index.html
                    plen_next  = INDEX_LEN;
                    ctype_next = CT_HTML;
                    idx_next   = 1'b1;
                end
                else
                begin
                    plen_next  = path_cnt_next;
                    ctype_next = suffix_kind(sfx_next, path_cnt_next);
                end
            end
            else if (byte_count_next >= BYTE_LIMIT)
            begin
                verdict     = 1'b1;
                status_next = ST_TOO_LARGE;
            end

            if (verdict)
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            term_prog_reg  <= '0;
            meth_prog_reg  <= '0;
            meth_bad_reg   <= 1'b0;
            phase_reg      <= PH_METHOD;
            path_cnt_reg   <= '0;
            prev_byte_reg  <= CH_DOT;
            dotdot_reg     <= 1'b0;
            sfx_reg        <= '0;
            first_byte_reg <= '0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                byte_count_reg <= byte_count_next;
                term_prog_reg  <= term_prog_next;
                meth_prog_reg  <= meth_prog_next;
                meth_bad_reg   <= meth_bad_next;
                phase_reg      <= phase_next;
                path_cnt_reg   <= path_cnt_next;
                prev_byte_reg  <= prev_byte_next;
                dotdot_reg     <= dotdot_next;
                sfx_reg        <= sfx_next;
                first_byte_reg <= first_byte_next;
                done_reg       <= done_next;
            end

            if (in_fire && verdict)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // verdict payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire && verdict)
        begin
            status_reg <= status_next;
            plen_reg   <= plen_next;
            ctype_reg  <= ctype_next;
            idx_reg    <= idx_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign path_length       = plen_reg;
    assign content_type      = ctype_reg;
    assign index_substituted = idx_reg;

endmodule
